>>> hdl/rqi_pkg.sv
// Shared widths, register indexes and helpers for the ray/quad intersection block.
// No dependencies.
package rqi_pkg;

   localparam int CRD_W      = 16;   // Q8.8 coordinate, Q2.14 direction
   localparam int EDGE_W     = 17;   // difference of two coordinates
   localparam int CRS_P_W    = 34;   // d x e2
   localparam int CRS_Q_W    = 35;   // tv x e1
   localparam int DOT_W      = 54;   // any of the dot products
   localparam int DEN_W      = 53;   // |det|
   localparam int FRAC_SHIFT = 22;
   localparam int QUO_W      = 32;
   localparam int REM_W      = DOT_W + FRAC_SHIFT;
   localparam int DSH_W      = DEN_W + QUO_W;
   localparam int PROD_W     = QUO_W + CRD_W;
   localparam int FLR_W      = PROD_W - FRAC_SHIFT;
   localparam int PSUM_W     = FLR_W + 1;
   localparam int CSR_IDX_W  = 8;
   localparam int CORNER_W   = 3 * CRD_W;
   localparam int REQ_W      = 6 * CRD_W;
   localparam int RSP_W      = QUO_W + 3 * CRD_W;

   localparam logic [CSR_IDX_W-1:0] CSR_CORNER_A = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CORNER_B = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CORNER_C = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CORNER_D = 8'd3;

   typedef logic signed [CRD_W-1:0]   crd_type;
   typedef logic signed [EDGE_W-1:0]  edge_type;
   typedef logic signed [CRS_P_W-1:0] crsp_type;
   typedef logic signed [CRS_Q_W-1:0] crsq_type;
   typedef logic signed [DOT_W-1:0]   dot_type;

   // axis 0 = x (bits 47:32), 1 = y, 2 = z
   function automatic crd_type corner_axis(input logic [CORNER_W-1:0] r, input int axis);
      crd_type v;
      v = crd_type'(r[CORNER_W-1-CRD_W*axis -: CRD_W]);
      return v;
   endfunction

   function automatic logic [CRD_W-1:0] sat16(input logic signed [PSUM_W-1:0] x);
      logic [CRD_W-1:0] r;
      if (x > PSUM_W'(32767))
         r = 16'h7FFF;
      else if (x < -PSUM_W'(32768))
         r = 16'h8000;
      else
         r = x[CRD_W-1:0];
      return r;
   endfunction

   function automatic logic inside_open(input dot_type n, input dot_type det);
      logic r;
      if (det > 0)
         r = (n > 0) && (n < det);
      else
         r = (n < 0) && (n > det);
      return r;
   endfunction

endpackage

>>> hdl/ray_quad_intersection_top.sv
// Top level: pipelined Moller-Trumbore ray test against a quad held as two parallelograms.
// Depends on rqi_pkg.
//
// Usage:
//   req channel: one ray per beat, origin (Q8.8) and direction (Q2.14).
//   rsp channel: one result per ray, in order; hit flag in tuser, t (Q16.16)
//     and hit point (Q8.8) in tdata, all zero on a miss.
//   csr channel: writes corner A..D (index 0..3), always ready; other
//     indexes are dropped. Write corners only while no ray is in flight.
// From req beat to rsp beat a ray passes the vector math stages (edges,
// cross products, dot products, inside tests, magnitudes), a 32-stage
// restoring divider giving one quotient bit per stage, then saturation,
// the t*d multiply and the final add. Throughput is one ray per cycle
// unless the output stalls; the whole pipeline advances together.
// When the receiver stalls a full output register, every stage holds and
// req_tready drops in the same cycle; nothing is dropped or repeated.
// Reset clears all stage valid bits and the corner registers to zero.
// The csr port takes no part in the stall.
module ray_quad_intersection_top
   import rqi_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (16 bits each, low first)
   input  logic [REQ_W-1:0]     req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // distance[31:0], point_x, point_y, point_z (16 bits each)
   output logic [RSP_W-1:0]     rsp_tdata,
   // hit
   output logic [0:0]           rsp_tuser,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CORNER_W-1:0]  csr_data
);

   localparam int DIV_BASE = 4;                 // stage holding the divider seed
   localparam int NSTAGE   = DIV_BASE + QUO_W + 4;

   logic adv;
   logic [NSTAGE-1:0] vld_ff;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = vld_ff[NSTAGE-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NSTAGE-2:0], req_tvalid};
      end
   end

   // ---------------- corner registers
   logic [CORNER_W-1:0] corner_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) corner_ff[i] <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CORNER_A: corner_ff[0] <= csr_data;
            CSR_CORNER_B: corner_ff[1] <= csr_data;
            CSR_CORNER_C: corner_ff[2] <= csr_data;
            CSR_CORNER_D: corner_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   // Edges depend on configuration only; quad 0 is based at A, quad 1 at D.
   crd_type  base_w [2][3];
   edge_type e1_w [2][3];
   edge_type e2_w [2][3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         base_w[0][i] = corner_axis(corner_ff[0], i);
         base_w[1][i] = corner_axis(corner_ff[3], i);
         for (int k = 0; k < 2; k++) begin
            e1_w[k][i] = edge_type'(corner_axis(corner_ff[1], i)) - edge_type'(base_w[k][i]);
            e2_w[k][i] = edge_type'(corner_axis(corner_ff[2], i)) - edge_type'(base_w[k][i]);
         end
      end
   end

   // ---------------- stage 1: capture, T = o - base
   crd_type  o1_ff [3], d1_ff [3];
   edge_type tv1_ff [2][3];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            o1_ff[i] <= crd_type'(req_tdata[CRD_W*i +: CRD_W]);
            d1_ff[i] <= crd_type'(req_tdata[CRD_W*(3+i) +: CRD_W]);
            for (int k = 0; k < 2; k++)
               tv1_ff[k][i] <= edge_type'(crd_type'(req_tdata[CRD_W*i +: CRD_W]))
                             - edge_type'(base_w[k][i]);
         end
      end
   end

   // ---------------- stage 2: P = d x E2, Q = T x E1
   crd_type  o2_ff [3], d2_ff [3];
   edge_type tv2_ff [2][3];
   crsp_type p2_ff [2][3];
   crsq_type q2_ff [2][3];

   always_ff @(posedge clock) begin
      if (adv) begin
         o2_ff  <= o1_ff;
         d2_ff  <= d1_ff;
         tv2_ff <= tv1_ff;
         for (int k = 0; k < 2; k++) begin
            for (int i = 0; i < 3; i++) begin
               p2_ff[k][i] <= crsp_type'(d1_ff[(i+1)%3]) * crsp_type'(e2_w[k][(i+2)%3])
                            - crsp_type'(d1_ff[(i+2)%3]) * crsp_type'(e2_w[k][(i+1)%3]);
               q2_ff[k][i] <= crsq_type'(tv1_ff[k][(i+1)%3]) * crsq_type'(e1_w[k][(i+2)%3])
                            - crsq_type'(tv1_ff[k][(i+2)%3]) * crsq_type'(e1_w[k][(i+1)%3]);
            end
         end
      end
   end

   // ---------------- stage 3: det, u and v numerators, t numerator
   crd_type o3_ff [3], d3_ff [3];
   dot_type det3_ff [2], un3_ff [2], vn3_ff [2], tn3_ff [2];

   always_ff @(posedge clock) begin
      if (adv) begin
         o3_ff <= o2_ff;
         d3_ff <= d2_ff;
         for (int k = 0; k < 2; k++) begin
            det3_ff[k] <= dot_type'(e1_w[k][0]) * dot_type'(p2_ff[k][0])
                        + dot_type'(e1_w[k][1]) * dot_type'(p2_ff[k][1])
                        + dot_type'(e1_w[k][2]) * dot_type'(p2_ff[k][2]);
            un3_ff[k]  <= dot_type'(tv2_ff[k][0]) * dot_type'(p2_ff[k][0])
                        + dot_type'(tv2_ff[k][1]) * dot_type'(p2_ff[k][1])
                        + dot_type'(tv2_ff[k][2]) * dot_type'(p2_ff[k][2]);
            vn3_ff[k]  <= dot_type'(d2_ff[0]) * dot_type'(q2_ff[k][0])
                        + dot_type'(d2_ff[1]) * dot_type'(q2_ff[k][1])
                        + dot_type'(d2_ff[2]) * dot_type'(q2_ff[k][2]);
            tn3_ff[k]  <= dot_type'(e2_w[k][0]) * dot_type'(q2_ff[k][0])
                        + dot_type'(e2_w[k][1]) * dot_type'(q2_ff[k][1])
                        + dot_type'(e2_w[k][2]) * dot_type'(q2_ff[k][2]);
         end
      end
   end

   // ---------------- stage 4: inside tests, first quad wins
   crd_type o4_ff [3], d4_ff [3];
   dot_type det4_ff, tn4_ff;
   logic    hit4_ff;
   logic    hit_a_w, hit_d_w;

   assign hit_a_w = (det3_ff[0] != '0) && inside_open(un3_ff[0], det3_ff[0])
                    && inside_open(vn3_ff[0], det3_ff[0]);
   assign hit_d_w = (det3_ff[1] != '0) && inside_open(un3_ff[1], det3_ff[1])
                    && inside_open(vn3_ff[1], det3_ff[1]);

   always_ff @(posedge clock) begin
      if (adv) begin
         o4_ff   <= o3_ff;
         d4_ff   <= d3_ff;
         hit4_ff <= hit_a_w || hit_d_w;
         det4_ff <= hit_a_w ? det3_ff[0] : det3_ff[1];
         tn4_ff  <= hit_a_w ? tn3_ff[0] : tn3_ff[1];
      end
   end

   // ---------------- stage 5 and divider: |tnum| * 2^22 / |det|
   logic [REM_W-1:0] rem_ff [QUO_W+1];
   logic [QUO_W-1:0] quo_ff [QUO_W+1];
   logic [DEN_W-1:0] dd_ff  [QUO_W+1];
   logic             neg_ff [QUO_W+1];
   logic             sat_ff [QUO_W+1];
   logic             hitd_ff [QUO_W+1];
   crd_type          od_ff [QUO_W+1][3];
   crd_type          dd3_ff [QUO_W+1][3];

   logic [DOT_W-1:0] nmag_w, dmag_w;
   assign nmag_w = tn4_ff[DOT_W-1] ? DOT_W'(-tn4_ff) : DOT_W'(tn4_ff);
   assign dmag_w = det4_ff[DOT_W-1] ? DOT_W'(-det4_ff) : DOT_W'(det4_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0]  <= {nmag_w, {FRAC_SHIFT{1'b0}}};
         quo_ff[0]  <= '0;
         dd_ff[0]   <= dmag_w[DEN_W-1:0];
         neg_ff[0]  <= tn4_ff[DOT_W-1] ^ det4_ff[DOT_W-1];
         // quotient reaches 2^32 exactly when |tnum| >= |det| * 2^10
         sat_ff[0]  <= {{(DEN_W+10-DOT_W){1'b0}}, nmag_w}
                       >= {dmag_w[DEN_W-1:0], 10'b0};
         hitd_ff[0] <= hit4_ff;
         od_ff[0]   <= o4_ff;
         dd3_ff[0]  <= d4_ff;
      end
   end

   for (genvar j = 0; j < QUO_W; j++) begin : g_div
      logic [DSH_W-1:0] dsh_w, rx_w, diff_w;
      logic             ge_w;

      assign dsh_w  = {{QUO_W{1'b0}}, dd_ff[j]} << (QUO_W - 1 - j);
      assign rx_w   = {{(DSH_W-REM_W){1'b0}}, rem_ff[j]};
      assign ge_w   = rx_w >= dsh_w;
      assign diff_w = rx_w - dsh_w;

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[j+1]  <= ge_w ? diff_w[REM_W-1:0] : rem_ff[j];
            quo_ff[j+1]  <= {quo_ff[j][QUO_W-2:0], ge_w};
            dd_ff[j+1]   <= dd_ff[j];
            neg_ff[j+1]  <= neg_ff[j];
            sat_ff[j+1]  <= sat_ff[j];
            hitd_ff[j+1] <= hitd_ff[j];
            od_ff[j+1]   <= od_ff[j];
            dd3_ff[j+1]  <= dd3_ff[j];
         end
      end
   end

   // ---------------- signed, saturated t
   logic signed [QUO_W-1:0] t_in, t_ff;
   logic                    hitt_ff;
   crd_type                 ot_ff [3], dt_ff [3];
   logic                    big_w;

   assign big_w = sat_ff[QUO_W] || quo_ff[QUO_W][QUO_W-1];

   always_comb begin
      if (!hitd_ff[QUO_W])
         t_in = '0;
      else if (neg_ff[QUO_W])
         t_in = big_w ? {1'b1, {(QUO_W-1){1'b0}}} : -quo_ff[QUO_W];
      else
         t_in = big_w ? {1'b0, {(QUO_W-1){1'b1}}} : quo_ff[QUO_W];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t_ff    <= t_in;
         hitt_ff <= hitd_ff[QUO_W];
         ot_ff   <= od_ff[QUO_W];
         dt_ff   <= dd3_ff[QUO_W];
      end
   end

   // ---------------- t * d
   logic signed [PROD_W-1:0] pr_ff [3];
   logic signed [QUO_W-1:0]  tm_ff;
   logic                     hitm_ff;
   crd_type                  om_ff [3];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++)
            pr_ff[i] <= PROD_W'(t_ff) * PROD_W'(dt_ff[i]);
         tm_ff   <= t_ff;
         hitm_ff <= hitt_ff;
         om_ff   <= ot_ff;
      end
   end

   // ---------------- floor, add origin, saturate; output register
   logic [RSP_W-1:0] rsp_data_ff;
   logic             rsp_hit_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_hit_ff <= hitm_ff;
         rsp_data_ff[QUO_W-1:0] <= tm_ff;
         for (int i = 0; i < 3; i++) begin
            rsp_data_ff[QUO_W+CRD_W*i +: CRD_W] <= hitm_ff
               ? sat16(PSUM_W'(om_ff[i]) + PSUM_W'(pr_ff[i] >>> FRAC_SHIFT))
               : '0;
         end
      end
   end

   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_hit_ff;

endmodule

>>> hdl/rqi_checker.sv
// Port-level checks for ray_quad_intersection_top, bound to every instance.
// No package dependency.
module rqi_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata,
   input logic [0:0]  rsp_tuser,
   input logic        csr_ready
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp beat changed while stalled");

   // a miss carries all-zero data
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 80'd0)
      else $error("miss with nonzero data");

   // empty output stage never blocks input
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low with empty output");

   // a stalled output stalls the input but leaves csr ready
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready && csr_ready)
      else $error("req_tready high during output stall");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid after reset");

endmodule

bind ray_quad_intersection_top rqi_checker u_rqi_checker (.*);

>>> sim/ray_quad_intersection_top_test.sv
// Testbench for the ray/quad intersection block: random and directed rays against
// several quad settings, checked beat by beat against an in-bench fixed-point predictor.
// Depends on rqi_pkg and ray_quad_intersection_top.
module ray_quad_intersection_top_test;
   import rqi_pkg::*;

   // ordered so that {rsp_tuser, rsp_tdata} maps straight onto it
   typedef struct packed {
      logic                     hit;
      logic signed [CRD_W-1:0]  pz;
      logic signed [CRD_W-1:0]  py;
      logic signed [CRD_W-1:0]  px;
      logic signed [QUO_W-1:0]  tdist;
   } isect_type;

   typedef struct {
      bit                       is_csr;
      logic [CSR_IDX_W-1:0]     idx;
      logic [CORNER_W-1:0]      val;
      logic [REQ_W-1:0]         ray;
   } job_type;

   localparam int WATCHDOG = 5000;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_W-1:0] rsp_tdata;
   logic [0:0] rsp_tuser;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CORNER_W-1:0] csr_data = '0;

   ray_quad_intersection_top dut (.*);

   always #5 clock = ~clock;

   job_type   pending[$];
   isect_type expected_hits[$];
   logic [CORNER_W-1:0] corners[4];
   int  failures = 0;
   int  rays_sent = 0, hits_seen = 0, results_seen = 0;
   bit  calm = 0;       // no idling near the end
   int  tx_gap = 0, rx_gap = 0, idle_cycles = 0;
   bit  busy_wait;      // hold-off: wait until queue of expectations drains

   // ---------------- predictor ----------------
   function automatic longint sx(logic [15:0] v);
      return longint'($signed(v));
   endfunction

   function automatic bit open_range(longint n, longint dt);
      if (dt > 0) return n > 0 && n < dt;
      return n < 0 && n > dt;
   endfunction

   function automatic bit para_hit(longint o[3], longint d[3], longint bs[3],
                                   longint pb[3], longint pc[3],
                                   output longint tn, output longint dt);
      longint e1[3], e2[3], tv[3], p[3], q[3];
      for (int i = 0; i < 3; i++) begin
         e1[i] = pb[i] - bs[i];
         e2[i] = pc[i] - bs[i];
         tv[i] = o[i] - bs[i];
      end
      p[0] = d[1]*e2[2] - d[2]*e2[1];
      p[1] = d[2]*e2[0] - d[0]*e2[2];
      p[2] = d[0]*e2[1] - d[1]*e2[0];
      dt = e1[0]*p[0] + e1[1]*p[1] + e1[2]*p[2];
      tn = 0;
      if (dt == 0) return 0;
      q[0] = tv[1]*e1[2] - tv[2]*e1[1];
      q[1] = tv[2]*e1[0] - tv[0]*e1[2];
      q[2] = tv[0]*e1[1] - tv[1]*e1[0];
      if (!open_range(tv[0]*p[0] + tv[1]*p[1] + tv[2]*p[2], dt)) return 0;
      if (!open_range(d[0]*q[0] + d[1]*q[1] + d[2]*q[2], dt)) return 0;
      tn = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
      return 1;
   endfunction

   function automatic longint t_q16(longint tn, longint dt);
      longint unsigned n, dd, qt, rm;
      bit neg, sat;
      n  = tn < 0 ? -tn : tn;
      dd = dt < 0 ? -dt : dt;
      qt = n / dd;
      rm = n % dd;
      neg = (tn < 0) != (dt < 0);
      sat = qt >= 64'h1_0000_0000;
      for (int i = 0; i < FRAC_SHIFT && !sat; i++) begin
         rm = rm << 1;
         qt = qt << 1;
         if (rm >= dd) begin
            rm -= dd;
            qt |= 1;
         end
         if (qt >= 64'h1_0000_0000) sat = 1;
      end
      if (neg) return (sat || qt >= 64'h8000_0000) ? -64'sd2147483648 : -longint'(qt);
      return (sat || qt > 64'h7FFF_FFFF) ? 64'sd2147483647 : longint'(qt);
   endfunction

   function automatic longint floor22(longint x);
      if (x >= 0) return x >>> FRAC_SHIFT;
      return -((-x + (64'sd1 << FRAC_SHIFT) - 1) >>> FRAC_SHIFT);
   endfunction

   function automatic isect_type intersect_ray(logic [REQ_W-1:0] ray);
      longint o[3], d[3], a[3], b[3], c[3], dc[3], tn, dt, t, s;
      bit h;
      isect_type r;
      for (int i = 0; i < 3; i++) begin
         o[i]  = sx(ray[16*i +: 16]);
         d[i]  = sx(ray[16*(3+i) +: 16]);
         a[i]  = sx(corners[CSR_CORNER_A][47-16*i -: 16]);
         b[i]  = sx(corners[CSR_CORNER_B][47-16*i -: 16]);
         c[i]  = sx(corners[CSR_CORNER_C][47-16*i -: 16]);
         dc[i] = sx(corners[CSR_CORNER_D][47-16*i -: 16]);
      end
      h = para_hit(o, d, a, b, c, tn, dt);
      if (!h) h = para_hit(o, d, dc, b, c, tn, dt);
      r = '0;
      if (!h) return r;
      t = t_q16(tn, dt);
      r.hit   = 1;
      r.tdist = t[31:0];
      for (int i = 0; i < 3; i++) begin
         s = o[i] + floor22(t * d[i]);
         if (s > 32767) s = 32767;
         if (s < -32768) s = -32768;
         case (i)
            0: r.px = s[15:0];
            1: r.py = s[15:0];
            default: r.pz = s[15:0];
         endcase
      end
      return r;
   endfunction

   // ---------------- driver ----------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_hits.push_back(intersect_ray(req_tdata));
            rays_sent++;
         end
         if (csr_valid && csr_ready) begin
            if (csr_index < 4) corners[csr_index] = csr_data;
         end
         if ((req_tvalid && !req_tready) || (csr_valid && !csr_ready)) begin
            // hold current beat
         end else if (tx_gap > 0) begin
            tx_gap--;
            req_tvalid <= 0;
            csr_valid  <= 0;
         end else if (pending.size() > 0 &&
                      !(pending[0].is_csr &&
                        (busy_wait || req_tvalid || expected_hits.size() != 0))) begin
            if (!calm && $urandom_range(0, 7) == 0) begin
               tx_gap = $urandom_range(0, 2);
               req_tvalid <= 0;
               csr_valid  <= 0;
            end else begin
               job_type j;
               j = pending.pop_front();
               if (j.is_csr) begin
                  csr_index  <= j.idx;
                  csr_data   <= j.val;
                  csr_valid  <= 1;
                  req_tvalid <= 0;
               end else begin
                  req_tdata  <= j.ray;
                  req_tvalid <= 1;
                  csr_valid  <= 0;
               end
            end
         end else begin
            req_tvalid <= 0;
            csr_valid  <= 0;
         end
      end
   end

   // csr writes only after the pipe drains plus a margin
   int drain_count = 0;
   always @(posedge clock) begin
      if (expected_hits.size() != 0 || req_tvalid) drain_count <= 0;
      else if (drain_count < 50) drain_count <= drain_count + 1;
   end
   assign busy_wait = (drain_count < 50);

   // ---------------- monitor ----------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            isect_type got, exp_r;
            got = {rsp_tuser[0], rsp_tdata};
            results_seen++;
            if (expected_hits.size() == 0) begin
               $error("unexpected result beat: %h", got);
               failures++;
            end else begin
               exp_r = expected_hits.pop_front();
               if (got.hit !== exp_r.hit) begin
                  $error("hit: expected %0d actual %0d", exp_r.hit, got.hit);
                  failures++;
               end
               if (got.tdist !== exp_r.tdist) begin
                  $error("distance: expected %0d actual %0d", exp_r.tdist, got.tdist);
                  failures++;
               end
               if (got.px !== exp_r.px) begin
                  $error("point_x: expected %0d actual %0d", exp_r.px, got.px);
                  failures++;
               end
               if (got.py !== exp_r.py) begin
                  $error("point_y: expected %0d actual %0d", exp_r.py, got.py);
                  failures++;
               end
               if (got.pz !== exp_r.pz) begin
                  $error("point_z: expected %0d actual %0d", exp_r.pz, got.pz);
                  failures++;
               end
               if (exp_r.hit) hits_seen++;
            end
         end
         if (rx_gap > 0) begin
            rx_gap--;
            rsp_tready <= 0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rx_gap = $urandom_range(0, 2);
            rsp_tready <= 0;
         end else begin
            rsp_tready <= 1;
         end
      end
   end

   // watchdog on cycles with no beat of any kind
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready) || pending.size() == 0 && expected_hits.size() == 0)
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG) begin
         $display("Test completed with failures");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // ---------------- stimulus ----------------
   function automatic logic [15:0] pick16();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] near16(logic [15:0] c, int span);
      longint v;
      v = sx(c) + longint'($urandom_range(0, 2*span)) - span;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   task automatic add_ray(logic [REQ_W-1:0] r);
      job_type j;
      j.is_csr = 0;
      j.ray = r;
      pending.push_back(j);
   endtask

   task automatic add_csr(logic [CSR_IDX_W-1:0] i, logic [CORNER_W-1:0] v);
      job_type j;
      j.is_csr = 1;
      j.idx = i;
      j.val = v;
      pending.push_back(j);
   endtask

   // ray aimed at a random point of the quad so that hits are common
   function automatic logic [REQ_W-1:0] aimed_ray(logic [CORNER_W-1:0] q[4]);
      logic [REQ_W-1:0] r;
      longint tgt[3], org[3], dv[3], m, mag;
      int wu, wv;
      wu = $urandom_range(0, 255);
      wv = $urandom_range(0, 255);
      for (int i = 0; i < 3; i++) begin
         tgt[i] = sx(q[0][47-16*i -: 16]) +
                  ((sx(q[1][47-16*i -: 16]) - sx(q[0][47-16*i -: 16])) * wu
                 + (sx(q[2][47-16*i -: 16]) - sx(q[0][47-16*i -: 16])) * wv) / 512;
         org[i] = sx(pick16()) / longint'($urandom_range(1, 8));
         dv[i] = tgt[i] - org[i];
      end
      m = 1;
      for (int i = 0; i < 3; i++) begin
         mag = dv[i] < 0 ? -dv[i] : dv[i];
         if (mag > m) m = mag;
      end
      for (int i = 0; i < 3; i++) begin
         r[16*i +: 16] = org[i][15:0];
         r[16*(3+i) +: 16] = 16'((dv[i] * 32767) / m);
      end
      return r;
   endfunction

   initial begin
      logic [CORNER_W-1:0] q[4];
      int n;
      for (int i = 0; i < 4; i++) corners[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 0;

      // directed: zero quad first (degenerate), then a 2 x 2 square at z = 4
      add_ray({6{16'h0000}});
      q[0] = {16'shFF00, 16'shFF00, 16'h0400};
      q[1] = {16'h0100, 16'shFF00, 16'h0400};
      q[2] = {16'shFF00, 16'h0100, 16'h0400};
      q[3] = {16'h0100, 16'h0100, 16'h0400};
      for (int i = 0; i < 4; i++) add_csr(i[CSR_IDX_W-1:0], q[i]);
      add_csr(8'd7, 48'hFFFF_FFFF_FFFF);   // unknown index is dropped
      add_ray({16'h4000, 16'h0000, 16'h0000, 48'h0});             // straight hit, t = 4
      add_ray({16'h4000, 16'h0800, 16'h0800, 48'h0});             // off-centre hit, first quad wins
      add_ray({16'h4000, 16'h0000, 16'h0000, 16'h0, 16'h0, 16'h0100}); // edge u = 1 of quad 0, miss
      add_ray({16'h0000, 16'h4000, 16'h0000, 48'h0});             // parallel, det 0
      add_ray({16'hC000, 16'h0000, 16'h0000, 16'h0800, 16'h0, 16'h0}); // downward from z = 8, t = 4
      add_ray({16'h0001, 16'h0000, 16'h0000, 16'h0, 16'h0, 16'h0}); // tiny dir, big t
      add_ray({16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
      add_ray({16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
      add_ray({16'h0001, 16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h8000});
      add_ray({6{16'hFFFF}});

      // random phases with different quads, extremes among them
      for (int ph = 0; ph < 8; ph++) begin
         for (int i = 0; i < 4; i++) begin
            if (ph == 0) q[i] = {3{16'h7FFF}} ^ {48{i[0]}};
            else if (ph == 1) q[i] = i[1] ? {3{16'h8000}} : {3{16'h7FFF}};
            else q[i] = {pick16(), pick16(), pick16()};
            add_csr(i[CSR_IDX_W-1:0], q[i]);
         end
         q[3] = {near16(q[1][47:32], 0), near16(q[2][31:16], 0), q[3][15:0]};
         n = (ph == 7) ? 150 : 105;
         if (ph == 7) add_csr(CSR_CORNER_D, q[3]);
         for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 3) != 0)
               add_ray(aimed_ray(q));
            else
               add_ray({pick16(), pick16(), pick16(), pick16(), pick16(), pick16()});
         end
      end

      wait (pending.size() < 120);
      calm = 1;
      wait (pending.size() == 0 && !req_tvalid && !csr_valid);
      wait (expected_hits.size() == 0);
      repeat (60) @(posedge clock);
      $display("Covered %0d rays (%0d hits, %0d results) over 10 quad settings.",
               rays_sent, hits_seen, results_seen);
      if (failures == 0 && expected_hits.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
